### design/dcf77_time_code_encoder_assert.svh
// Assertion macros used by the time code encoder RTL.
`ifndef DCF77_TIME_CODE_ENCODER_ASSERT_SVH
`define DCF77_TIME_CODE_ENCODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define DCF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcf77 encoder: same-cycle check failed");
`define DCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcf77 encoder: next-cycle check failed");
`else
`define DCF_ASSERT_IMP(label, clk, rst, ante, cons)
`define DCF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/dcf_pkg.sv
// Types, constants and helper functions of the time code encoder.
`default_nettype none
package dcf_pkg;

  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned PulseCountW = 16;

  typedef logic [5:0] sec_t;
  typedef logic [5:0] min_t;
  typedef logic [4:0] hour_t;
  typedef logic [PulseCountW-1:0] pulse_count_t;
  typedef logic [CfgIndexW-1:0] cfg_index_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_SHORT_PULSE = 1'b0,
    REG_LONG_PULSE  = 1'b1
  } cfg_reg_t;

  localparam pulse_count_t SHORT_PULSE_RESET = 16'd31250;
  localparam pulse_count_t LONG_PULSE_RESET  = 16'd62500;

  localparam sec_t  SEC_PER_MIN  = 6'd60;
  localparam min_t  MIN_PER_HOUR = 6'd60;
  localparam hour_t HOUR_PER_DAY = 5'd24;

  localparam sec_t SEC_LAST      = 6'd59;
  localparam sec_t SEC_START     = 6'd20;
  localparam sec_t SEC_MIN_FIRST = 6'd21;
  localparam sec_t SEC_MIN_LAST  = 6'd27;
  localparam sec_t SEC_MIN_PAR   = 6'd28;
  localparam sec_t SEC_HOUR_FIRST = 6'd29;
  localparam sec_t SEC_HOUR_LAST = 6'd34;
  localparam sec_t SEC_HOUR_PAR  = 6'd35;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // Binary to packed BCD for values below 64; tens digit found by compares.
  function automatic logic [7:0] to_bcd(input logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] ones;
    if (v >= 6'd60) begin
      tens = 3'd6;
    end else if (v >= 6'd50) begin
      tens = 3'd5;
    end else if (v >= 6'd40) begin
      tens = 3'd4;
    end else if (v >= 6'd30) begin
      tens = 3'd3;
    end else if (v >= 6'd20) begin
      tens = 3'd2;
    end else if (v >= 6'd10) begin
      tens = 3'd1;
    end else begin
      tens = 3'd0;
    end
    ones = v - ({3'b000, tens} * 6'd10);
    return {1'b0, tens, ones[3:0]};
  endfunction

endpackage
`default_nettype wire

### design/dcf_req_if.sv
// Request channel: tick or time-of-day load.
`default_nettype none
interface dcf_req_if import dcf_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  req_type;
  hour_t load_hour;
  min_t  load_minute;
  sec_t  load_second;

  modport source (output valid, output req_type, output load_hour,
                  output load_minute, output load_second, input ready);
  modport sink (input valid, input req_type, input load_hour,
                input load_minute, input load_second, output ready);
endinterface
`default_nettype wire

### design/dcf_pulse_if.sv
// Result channel: one time code pulse description per request.
`default_nettype none
interface dcf_pulse_if import dcf_pkg::*; ();
  logic         valid;
  logic         ready;
  logic         pulse_on;
  logic         bit_value;
  pulse_count_t pulse_count;
  sec_t         second_index;

  modport source (output valid, output pulse_on, output bit_value,
                  output pulse_count, output second_index, input ready);
  modport sink (input valid, input pulse_on, input bit_value,
                input pulse_count, input second_index, output ready);
endinterface
`default_nettype wire

### design/dcf_cfg_if.sv
// Configuration write channel.
`default_nettype none
interface dcf_cfg_if import dcf_pkg::*; ();
  logic         valid;
  logic         ready;
  cfg_index_t   reg_index;
  pulse_count_t data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
endinterface
`default_nettype wire

### design/dcf_frame_enc.sv
// Selects the time code bit for one second of the frame.
`default_nettype none
module dcf_frame_enc import dcf_pkg::*; (
  input  sec_t       second,
  input  logic [6:0] minute_bcd,
  input  logic [5:0] hour_bcd,
  output logic       bit_value
);

  sec_t       min_off;
  sec_t       hour_off;
  logic [7:0] min_bits;
  logic [7:0] hour_bits;

  assign min_off   = second - SEC_MIN_FIRST;
  assign hour_off  = second - SEC_HOUR_FIRST;
  assign min_bits  = {1'b0, minute_bcd};
  assign hour_bits = {2'b00, hour_bcd};

  always_comb begin
    if (second == SEC_START) begin
      bit_value = 1'b1;
    end else if (second >= SEC_MIN_FIRST && second <= SEC_MIN_LAST) begin
      bit_value = min_bits[min_off[2:0]];
    end else if (second == SEC_MIN_PAR) begin
      bit_value = ^minute_bcd;
    end else if (second >= SEC_HOUR_FIRST && second <= SEC_HOUR_LAST) begin
      bit_value = hour_bits[hour_off[2:0]];
    end else if (second == SEC_HOUR_PAR) begin
      bit_value = ^hour_bcd;
    end else begin
      bit_value = 1'b0;
    end
  end

endmodule
`default_nettype wire

### design/dcf77_time_code_encoder.sv
// The time of day and the latched BCD fields live in registers, a tick is
// encoded by one level of bit selection and counter increment, and the result
// sits in a single output register in the cycle after a request is taken. A
// new request is taken every cycle as long as the result register is empty or
// being read in the same cycle, so throughput is one request per clock. A tick
// reports the pulse for the current second (none in second 59) and then
// advances the time; a load sets the time (values out of range become zero)
// and reports no pulse. Pulse length compare values are written on the
// configuration channel and should only change while no request is in flight.
`default_nettype none
`include "dcf77_time_code_encoder_assert.svh"
module dcf77_time_code_encoder import dcf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  dcf_req_if.sink    req,
  dcf_pulse_if.source pulse,
  dcf_cfg_if.sink    cfg
);

  hour_t        hour_count;
  min_t         minute_count;
  sec_t         second_count;
  logic [6:0]   latched_minute_bcd;
  logic [5:0]   latched_hour_bcd;
  pulse_count_t short_pulse_count;
  pulse_count_t long_pulse_count;

  logic         out_valid;
  logic         out_pulse_on;
  logic         out_bit_value;
  pulse_count_t out_pulse_count;
  sec_t         out_second_index;

  logic         req_accept;
  logic         frame_bit;
  logic [7:0]   minute_bcd_full;
  logic [7:0]   hour_bcd_full;

  hour_t        hour_count_next;
  min_t         minute_count_next;
  sec_t         second_count_next;
  logic         res_pulse_on;
  logic         res_bit_value;
  pulse_count_t res_pulse_count;
  sec_t         res_second_index;

  assign req.ready  = !out_valid || pulse.ready;
  assign req_accept = req.valid && req.ready;
  assign cfg.ready  = 1'b1;

  assign minute_bcd_full = to_bcd(minute_count);
  assign hour_bcd_full   = to_bcd({1'b0, hour_count});

  dcf_frame_enc u_frame_enc (
    .second     (second_count),
    .minute_bcd (latched_minute_bcd),
    .hour_bcd   (latched_hour_bcd),
    .bit_value  (frame_bit)
  );

  always_comb begin
    hour_count_next   = hour_count;
    minute_count_next = minute_count;
    second_count_next = second_count;
    res_pulse_on      = 1'b0;
    res_bit_value     = 1'b0;
    res_pulse_count   = '0;
    res_second_index  = second_count;
    if (req.req_type == REQ_LOAD) begin
      hour_count_next   = (req.load_hour >= HOUR_PER_DAY) ? '0 : req.load_hour;
      minute_count_next = (req.load_minute >= MIN_PER_HOUR) ? '0 : req.load_minute;
      second_count_next = (req.load_second >= SEC_PER_MIN) ? '0 : req.load_second;
      res_second_index  = second_count_next;
    end else begin
      if (second_count != SEC_LAST) begin
        res_pulse_on    = 1'b1;
        res_bit_value   = frame_bit;
        res_pulse_count = frame_bit ? long_pulse_count : short_pulse_count;
      end
      // Second, minute and hour roll over in a chain.
      if (second_count >= SEC_LAST) begin
        second_count_next = '0;
        if (minute_count >= MIN_PER_HOUR - 6'd1) begin
          minute_count_next = '0;
          if (hour_count >= HOUR_PER_DAY - 5'd1) begin
            hour_count_next = '0;
          end else begin
            hour_count_next = hour_count + 5'd1;
          end
        end else begin
          minute_count_next = minute_count + 6'd1;
        end
      end else begin
        second_count_next = second_count + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count         <= '0;
      minute_count       <= '0;
      second_count       <= '0;
      latched_minute_bcd <= '0;
      latched_hour_bcd   <= '0;
      short_pulse_count  <= SHORT_PULSE_RESET;
      long_pulse_count   <= LONG_PULSE_RESET;
      out_valid          <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.reg_index)
          REG_SHORT_PULSE: short_pulse_count <= cfg.data;
          REG_LONG_PULSE:  long_pulse_count  <= cfg.data;
          default: ;
        endcase
      end
      if (req_accept) begin
        hour_count   <= hour_count_next;
        minute_count <= minute_count_next;
        second_count <= second_count_next;
        // The frame fields are captured at the start of each minute.
        if (req.req_type == REQ_TICK && second_count == '0) begin
          latched_minute_bcd <= minute_bcd_full[6:0];
          latched_hour_bcd   <= hour_bcd_full[5:0];
        end
        out_valid <= 1'b1;
      end else if (pulse.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      out_pulse_on     <= res_pulse_on;
      out_bit_value    <= res_bit_value;
      out_pulse_count  <= res_pulse_count;
      out_second_index <= res_second_index;
    end
  end

  assign pulse.valid        = out_valid;
  assign pulse.pulse_on     = out_pulse_on;
  assign pulse.bit_value    = out_bit_value;
  assign pulse.pulse_count  = out_pulse_count;
  assign pulse.second_index = out_second_index;

  `DCF_ASSERT_IMP(a_time_in_range, clk, rst, 1'b1, second_count < SEC_PER_MIN && minute_count < MIN_PER_HOUR && hour_count < HOUR_PER_DAY)
  `DCF_ASSERT_IMP(a_no_pulse_at_gap, clk, rst, out_valid && out_second_index == SEC_LAST, !out_pulse_on && !out_bit_value)
  `DCF_ASSERT_IMP(a_long_for_one, clk, rst, out_valid && out_pulse_on && out_bit_value, out_pulse_count == long_pulse_count)
  `DCF_ASSERT_NEXT(a_wrap_after_gap, clk, rst, req_accept && req.req_type == REQ_TICK && second_count == SEC_LAST, second_count == '0)
  `DCF_ASSERT_NEXT(a_result_follows_request, clk, rst, req_accept, out_valid)

endmodule
`default_nettype wire
